### rtl/cbsu_pkg.sv
// cbsu_pkg: types and opcode constants for the CB-prefix bit/shift unit.
// No dependencies; imported by every module of the unit.
`default_nettype none
package cbsu_pkg;

  localparam int unsigned NUM_SLOTS = 7;

  // Request kinds
  localparam logic REQ_EXEC = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Operand / load codes
  localparam logic [2:0] CODE_MEM   = 3'd6;  // operand byte at HL
  localparam logic [2:0] LOAD_FLAGS = 3'd6;  // load targets the flag nibble
  localparam logic [2:0] CODE_A     = 3'd7;
  localparam logic [2:0] SLOT_A     = 3'd6;
  localparam logic [2:0] SLOT_H     = 3'd4;
  localparam logic [2:0] SLOT_L     = 3'd5;

  // Opcode bits 7..6 group
  localparam logic [1:0] GRP_SHIFT = 2'b00;
  localparam logic [1:0] GRP_BIT   = 2'b01;
  localparam logic [1:0] GRP_RES   = 2'b10;
  localparam logic [1:0] GRP_SET   = 2'b11;

  // Shift/rotate kinds, opcode bits 5..3 within GRP_SHIFT
  localparam logic [2:0] SH_RLC  = 3'd0;
  localparam logic [2:0] SH_RRC  = 3'd1;
  localparam logic [2:0] SH_RL   = 3'd2;
  localparam logic [2:0] SH_RR   = 3'd3;
  localparam logic [2:0] SH_SLA  = 3'd4;
  localparam logic [2:0] SH_SRA  = 3'd5;
  localparam logic [2:0] SH_SWAP = 3'd6;
  localparam logic [2:0] SH_SRL  = 3'd7;

  typedef logic [NUM_SLOTS-1:0][7:0] regs_t;

  // Flag nibble: Z N H C
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // State update issued when a request retires
  typedef struct packed {
    logic       reg_en;
    logic [2:0] reg_slot;
    logic [7:0] reg_val;
    logic       flag_en;
    flags_t     flag_val;
  } state_wr_t;

  function automatic logic [2:0] slot_of(input logic [2:0] code);
    return (code == CODE_A) ? SLOT_A : code;
  endfunction

endpackage : cbsu_pkg
`default_nettype wire

### rtl/cb_prefix_bit_shift_unit_core.sv
// cb_prefix_bit_shift_unit_core: top level of the CB-prefix bit/shift unit.
// Depends on cbsu_pkg, cbsu_alu and cbsu_state.
`default_nettype none
// Executes one CB-prefixed opcode (or one register/flag load) per request on an
// internal B,C,D,E,H,L,A register file and Z/N/H/C flags. Every request gives
// exactly one result. A request is captured in an input register, worked on by
// the ALU in the next cycle and retired into the result register, at which
// point the register file and flags are updated; a request can therefore be
// taken every cycle while out_stall is low. out_valid rises when the request is
// retired from the input register into the result register.
// Throughput is one request per cycle, limited only by out_stall.
// Operand code 6 uses mem_read_data and always raises mem_write (BIT included,
// writing back the unchanged byte). mem_address reports HL as it stood before
// the request was executed.
module cb_prefix_bit_shift_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [7:0]  opcode,
  input  wire logic [7:0]  mem_read_data,
  input  wire logic [2:0]  load_index,
  input  wire logic [7:0]  load_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       result_value,
  output logic [3:0]       flags_out,
  output logic             mem_write,
  output logic [15:0]      mem_address,
  output logic [7:0]       mem_write_data
);
  import cbsu_pkg::*;

  // ---- input register ----
  logic       s1_valid;
  logic       s1_req_type;
  logic [7:0] s1_opcode;
  logic [7:0] s1_mem;
  logic [2:0] s1_lidx;
  logic [7:0] s1_lval;

  // Retire when the result register is free or being drained this cycle.
  logic advance;
  logic in_take;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_type <= req_type;
      s1_opcode   <= opcode;
      s1_mem      <= mem_read_data;
      s1_lidx     <= load_index;
      s1_lval     <= load_value;
    end
  end

  // ---- architectural state ----
  regs_t     regs;
  flags_t    flags;
  state_wr_t wr;

  cbsu_state u_state (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .regs  (regs),
    .flags (flags)
  );

  // ---- execute ----
  logic [2:0] code;
  logic       is_mem;
  logic [7:0] operand;
  logic [7:0] alu_result;
  flags_t     alu_flags;

  assign code    = s1_opcode[2:0];
  assign is_mem  = (code == CODE_MEM);
  assign operand = is_mem ? s1_mem : regs[slot_of(code)];

  cbsu_alu u_alu (
    .op       (s1_opcode[7:3]),
    .operand  (operand),
    .flags_in (flags),
    .result   (alu_result),
    .flags    (alu_flags)
  );

  logic [7:0]  result_next;
  flags_t      flags_next;
  logic        mem_write_next;
  logic [15:0] mem_address_next;

  assign mem_address_next = {regs[SLOT_H], regs[SLOT_L]};

  always_comb begin
    wr             = '0;
    result_next    = alu_result;
    flags_next     = alu_flags;
    mem_write_next = 1'b0;
    if (s1_req_type == REQ_LOAD) begin
      if (s1_lidx == LOAD_FLAGS) begin
        flags_next  = flags_t'(s1_lval[7:4]);
        result_next = {s1_lval[7:4], 4'h0};
        wr.flag_en  = advance;
      end else begin
        flags_next  = flags;
        result_next = s1_lval;
        wr.reg_en   = advance;
      end
      wr.reg_slot = slot_of(s1_lidx);
      wr.reg_val  = s1_lval;
    end else begin
      wr.flag_en     = advance;
      wr.reg_en      = advance && !is_mem;
      wr.reg_slot    = slot_of(code);
      wr.reg_val     = alu_result;
      mem_write_next = is_mem;
    end
    wr.flag_val = flags_next;
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_value   <= result_next;
      flags_out      <= flags_next;
      mem_write      <= mem_write_next;
      mem_address    <= mem_address_next;
      mem_write_data <= mem_write_next ? result_next : 8'h00;
    end
  end

endmodule : cb_prefix_bit_shift_unit_core
`default_nettype wire

### rtl/cbsu_alu.sv
// cbsu_alu: combinational CB-opcode datapath (rotates, shifts, SWAP, BIT/RES/SET).
// Depends on cbsu_pkg.
`default_nettype none
module cbsu_alu (
  input  wire logic [4:0]      op,
  input  wire logic [7:0]      operand,
  input  wire cbsu_pkg::flags_t flags_in,
  output logic [7:0]           result,
  output cbsu_pkg::flags_t     flags
);
  import cbsu_pkg::*;

  logic [2:0] n;
  logic       cin;
  logic       cout;
  logic [7:0] sh;
  logic [7:0] mask;

  assign n    = op[2:0];
  assign cin  = flags_in.c;
  assign mask = 8'd1 << n;

  always_comb begin
    cout = operand[0];
    unique case (n)
      SH_RLC:  begin sh = {operand[6:0], operand[7]}; cout = operand[7]; end
      SH_RRC:  sh = {operand[0], operand[7:1]};
      SH_RL:   begin sh = {operand[6:0], cin}; cout = operand[7]; end
      SH_RR:   sh = {cin, operand[7:1]};
      SH_SLA:  begin sh = {operand[6:0], 1'b0}; cout = operand[7]; end
      SH_SRA:  sh = {operand[7], operand[7:1]};
      SH_SWAP: begin sh = {operand[3:0], operand[7:4]}; cout = 1'b0; end
      SH_SRL:  sh = {1'b0, operand[7:1]};
      default: sh = operand;
    endcase
  end

  always_comb begin
    result = operand;
    flags  = flags_in;
    unique case (op[4:3])
      GRP_SHIFT: begin
        result = sh;
        flags  = '{z: (sh == 8'd0), n: 1'b0, h: 1'b0, c: cout};
      end
      GRP_BIT: flags = '{z: ~operand[n], n: 1'b0, h: 1'b1, c: cin};
      GRP_RES: result = operand & ~mask;
      GRP_SET: result = operand | mask;
      default: result = operand;
    endcase
  end

endmodule : cbsu_alu
`default_nettype wire

### rtl/cbsu_state.sv
// cbsu_state: register file B,C,D,E,H,L,A and the Z/N/H/C flag nibble.
// Depends on cbsu_pkg.
`default_nettype none
module cbsu_state (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cbsu_pkg::state_wr_t wr,
  output cbsu_pkg::regs_t          regs,
  output cbsu_pkg::flags_t         flags
);
  import cbsu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs  <= '0;
      flags <= '0;
    end else begin
      if (wr.reg_en) regs[wr.reg_slot] <= wr.reg_val;
      if (wr.flag_en) flags <= wr.flag_val;
    end
  end

endmodule : cbsu_state
`default_nettype wire
